### hdl/impq_pkg.sv
// Shared constants, command and status codes, and controller/datapath link types.
package impq_pkg;

   localparam int ID_BITS     = 6;
   localparam int ENTRIES     = 1 << ID_BITS;
   localparam int KEY_BITS    = 16;
   localparam int STAMP_BITS  = 32;
   localparam int WORD_BITS   = KEY_BITS + STAMP_BITS;
   localparam int CMD_BITS    = 2;
   localparam int STATUS_BITS = 3;

   localparam logic [CMD_BITS-1:0] CMD_INSERT = 2'd0;
   localparam logic [CMD_BITS-1:0] CMD_ADD    = 2'd1;
   localparam logic [CMD_BITS-1:0] CMD_REMOVE = 2'd2;
   localparam logic [CMD_BITS-1:0] CMD_QUERY  = 2'd3;

   localparam logic [STATUS_BITS-1:0] ST_OK        = 3'd0;
   localparam logic [STATUS_BITS-1:0] ST_EMPTY     = 3'd1;
   localparam logic [STATUS_BITS-1:0] ST_UNKNOWN   = 3'd2;
   localparam logic [STATUS_BITS-1:0] ST_PRESENT   = 3'd3;
   localparam logic [STATUS_BITS-1:0] ST_EXHAUSTED = 3'd4;

   typedef struct packed {
      logic capture;
      logic lookup;
      logic apply;
      logic scan_issue;
      logic load_rsp;
   } dp_ctrl_type;

   typedef struct packed {
      logic is_query;
      logic scan_last;
      logic rsp_blocked;
   } dp_stat_type;

endpackage

### hdl/indexed_max_priority_queue.sv
// Indexed max-priority queue: top level joining sequencer and datapath.
//
// Request channel (req_*): one command word per handshake - insert with a key,
// add an increment to a key (saturating), remove, or query the highest entry.
// Response channel (rsp_*): exactly one word per command, carrying a status and,
// for a successful query, the id and key of the greatest key (earliest stamp
// breaks ties); both are zero otherwise.
// Sequencing: insert, add and remove go through a lookup read, apply and result
// load. A query reads the entry store one entry per cycle through its single read
// port, then the result is loaded. One command is in work at a time.
// The result register lets a new word be accepted while the previous response
// still waits; if the receiver stalls, the following command completes its work
// and then holds until the result register is free.
// Reset clears all presence flags, the stamp counter and the handshake state;
// the entry store needs no clearing pass since an entry's data is used only while present.
module indexed_max_priority_queue import impq_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [CMD_BITS-1:0]    req_cmd,
   input  logic [ID_BITS-1:0]     req_entry_id,
   input  logic [KEY_BITS-1:0]    req_value,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [STATUS_BITS-1:0] rsp_status,
   output logic [ID_BITS-1:0]     rsp_top_id,
   output logic [KEY_BITS-1:0]    rsp_top_key
);

   dp_ctrl_type ctrl;
   dp_stat_type stat;

   impq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .ctrl      (ctrl)
   );

   impq_dp u_dp (
      .clock        (clock),
      .reset        (reset),
      .ctrl         (ctrl),
      .stat         (stat),
      .req_cmd      (req_cmd),
      .req_entry_id (req_entry_id),
      .req_value    (req_value),
      .rsp_ready    (rsp_ready),
      .rsp_valid    (rsp_valid),
      .rsp_status   (rsp_status),
      .rsp_top_id   (rsp_top_id),
      .rsp_top_key  (rsp_top_key)
   );

   // one command in work at a time
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request accepted while a command was in work");

   // never overwrite a response that has not been taken
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      ctrl.load_rsp |-> (!rsp_valid || rsp_ready))
      else $error("response register loaded while still occupied");

   a_zero_fields: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != ST_OK) |-> (rsp_top_id == '0 && rsp_top_key == '0))
      else $error("non-zero id or key on an error response");

   a_one_step: assert property (@(posedge clock) disable iff (reset)
      $onehot0({ctrl.capture, ctrl.lookup, ctrl.apply, ctrl.scan_issue, ctrl.load_rsp}))
      else $error("more than one sequencer step at once");

endmodule

### hdl/impq_ram.sv
// Generic single-write, single-read RAM with registered read data.
module impq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### hdl/impq_ctrl.sv
// Command sequencer: steps each word through lookup/apply or a full scan, then result load.
module impq_ctrl import impq_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  dp_stat_type stat,
   output dp_ctrl_type ctrl
);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_LOOKUP = 3'd1;
   localparam logic [2:0] S_APPLY  = 3'd2;
   localparam logic [2:0] S_SCAN   = 3'd3;
   localparam logic [2:0] S_DRAIN  = 3'd4;
   localparam logic [2:0] S_FINISH = 3'd5;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   always_comb begin
      state_in  = state_ff;
      ctrl      = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               ctrl.capture = 1'b1;
               state_in     = stat.is_query ? S_SCAN : S_LOOKUP;
            end
         end
         S_LOOKUP: begin
            ctrl.lookup = 1'b1;
            state_in    = S_APPLY;
         end
         S_APPLY: begin
            ctrl.apply = 1'b1;
            state_in   = S_FINISH;
         end
         S_SCAN: begin
            ctrl.scan_issue = 1'b1;
            if (stat.scan_last) begin
               state_in = S_DRAIN;
            end
         end
         // last read word is compared here
         S_DRAIN: begin
            state_in = S_FINISH;
         end
         S_FINISH: begin
            if (!stat.rsp_blocked) begin
               ctrl.load_rsp = 1'b1;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### hdl/impq_dp.sv
// Datapath: entry store, presence flags, stamp counter, scan comparator and result register.
module impq_dp import impq_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  dp_ctrl_type            ctrl,
   output dp_stat_type            stat,
   input  logic [CMD_BITS-1:0]    req_cmd,
   input  logic [ID_BITS-1:0]     req_entry_id,
   input  logic [KEY_BITS-1:0]    req_value,
   input  logic                   rsp_ready,
   output logic                   rsp_valid,
   output logic [STATUS_BITS-1:0] rsp_status,
   output logic [ID_BITS-1:0]     rsp_top_id,
   output logic [KEY_BITS-1:0]    rsp_top_key
);

   logic [CMD_BITS-1:0]    cmd_ff;
   logic [ID_BITS-1:0]     id_ff;
   logic [KEY_BITS-1:0]    value_ff;
   logic [ENTRIES-1:0]     present_ff;
   logic [STAMP_BITS-1:0]  next_stamp_ff;
   logic [ID_BITS-1:0]     scan_idx_ff;
   logic [ID_BITS-1:0]     cand_idx_ff;
   logic                   cand_valid_ff;
   logic                   best_found_ff;
   logic [ID_BITS-1:0]     best_id_ff;
   logic [KEY_BITS-1:0]    best_key_ff;
   logic [STAMP_BITS-1:0]  best_stamp_ff;
   logic [STATUS_BITS-1:0] res_status_ff;
   logic                   rsp_valid_ff;
   logic [STATUS_BITS-1:0] rsp_status_ff;
   logic [ID_BITS-1:0]     rsp_top_id_ff;
   logic [KEY_BITS-1:0]    rsp_top_key_ff;

   logic                   ram_wr_en;
   logic [WORD_BITS-1:0]   ram_wr_data;
   logic                   ram_rd_en;
   logic [ID_BITS-1:0]     ram_rd_addr;
   logic [WORD_BITS-1:0]   ram_rd_data;
   logic [KEY_BITS-1:0]    rd_key;
   logic [STAMP_BITS-1:0]  rd_stamp;

   logic                   hit;
   logic [KEY_BITS:0]      key_sum;
   logic [KEY_BITS-1:0]    sat_key;
   logic                   stamp_full;
   logic [STATUS_BITS-1:0] apply_status;
   logic                   do_write;
   logic                   do_set;
   logic                   do_clear;
   logic                   better;
   logic                   take;

   impq_ram #(
      .WIDTH (WORD_BITS),
      .DEPTH (ENTRIES)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (id_ff),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign ram_rd_en   = ctrl.lookup | ctrl.scan_issue;
   assign ram_rd_addr = ctrl.scan_issue ? scan_idx_ff : id_ff;
   assign rd_key      = ram_rd_data[WORD_BITS-1:STAMP_BITS];
   assign rd_stamp    = ram_rd_data[STAMP_BITS-1:0];

   // ids span the whole table, so every id is in range
   assign hit        = present_ff[id_ff];
   assign key_sum    = {1'b0, rd_key} + {1'b0, value_ff};
   assign sat_key    = key_sum[KEY_BITS] ? {KEY_BITS{1'b1}} : key_sum[KEY_BITS-1:0];
   assign stamp_full = &next_stamp_ff;

   always_comb begin
      apply_status = ST_OK;
      do_write     = 1'b0;
      do_set       = 1'b0;
      do_clear     = 1'b0;
      ram_wr_data  = {value_ff, next_stamp_ff};
      case (cmd_ff)
         CMD_INSERT: begin
            if (hit) begin
               apply_status = ST_PRESENT;
            end else if (stamp_full) begin
               apply_status = ST_EXHAUSTED;
            end else begin
               do_write = 1'b1;
               do_set   = 1'b1;
            end
         end
         CMD_ADD: begin
            if (!hit) begin
               apply_status = ST_UNKNOWN;
            end else begin
               do_write    = 1'b1;
               ram_wr_data = {sat_key, rd_stamp};
            end
         end
         CMD_REMOVE: begin
            if (!hit) begin
               apply_status = ST_UNKNOWN;
            end else begin
               do_clear = 1'b1;
            end
         end
         default: begin
            apply_status = ST_OK;
         end
      endcase
   end

   assign ram_wr_en = ctrl.apply & do_write;

   // greater key wins; on equal keys the earlier stamp
   assign better = !best_found_ff || (rd_key > best_key_ff) ||
                   ((rd_key == best_key_ff) && (rd_stamp < best_stamp_ff));
   assign take   = cand_valid_ff && present_ff[cand_idx_ff] && better;

   assign stat.is_query    = (req_cmd == CMD_QUERY);
   assign stat.scan_last   = (scan_idx_ff == ID_BITS'(ENTRIES - 1));
   assign stat.rsp_blocked = rsp_valid_ff & ~rsp_ready;

   // capture the word and hold it for the whole command
   always_ff @(posedge clock) begin
      if (ctrl.capture) begin
         cmd_ff   <= req_cmd;
         id_ff    <= req_entry_id;
         value_ff <= req_value;
      end
      if (ctrl.apply) begin
         res_status_ff <= apply_status;
      end
      if (ctrl.scan_issue) begin
         cand_idx_ff <= scan_idx_ff;
      end
      if (take) begin
         best_id_ff    <= cand_idx_ff;
         best_key_ff   <= rd_key;
         best_stamp_ff <= rd_stamp;
      end
      if (ctrl.load_rsp) begin
         if (cmd_ff == CMD_QUERY) begin
            rsp_status_ff  <= best_found_ff ? ST_OK : ST_EMPTY;
            rsp_top_id_ff  <= best_found_ff ? best_id_ff : '0;
            rsp_top_key_ff <= best_found_ff ? best_key_ff : '0;
         end else begin
            rsp_status_ff  <= res_status_ff;
            rsp_top_id_ff  <= '0;
            rsp_top_key_ff <= '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         present_ff    <= '0;
         next_stamp_ff <= '0;
         scan_idx_ff   <= '0;
         cand_valid_ff <= 1'b0;
         best_found_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (ctrl.apply && do_set) begin
            present_ff[id_ff] <= 1'b1;
            next_stamp_ff     <= next_stamp_ff + 1'b1;
         end
         if (ctrl.apply && do_clear) begin
            present_ff[id_ff] <= 1'b0;
         end
         if (ctrl.capture) begin
            scan_idx_ff <= '0;
         end else if (ctrl.scan_issue) begin
            scan_idx_ff <= scan_idx_ff + 1'b1;
         end
         cand_valid_ff <= ctrl.scan_issue;
         if (ctrl.capture) begin
            best_found_ff <= 1'b0;
         end else if (take) begin
            best_found_ff <= 1'b1;
         end
         rsp_valid_ff <= ctrl.load_rsp | (rsp_valid_ff & ~rsp_ready);
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_status  = rsp_status_ff;
   assign rsp_top_id  = rsp_top_id_ff;
   assign rsp_top_key = rsp_top_key_ff;

endmodule

### bench/testbench.sv
// Self-checking testbench for the indexed max-priority queue.
`timescale 1ns / 100ps

module testbench import impq_pkg::*; ();

   localparam int RANDOM_WORDS = 900;
   localparam int HOLD_CYCLES  = 400;
   localparam int QUIET_LIMIT  = 3000;
   localparam int TAIL_CYCLES  = ENTRIES + 40;

   typedef struct packed {
      logic [STATUS_BITS-1:0] status;
      logic [ID_BITS-1:0]     top_id;
      logic [KEY_BITS-1:0]    top_key;
   } answer_type;

   typedef struct {
      logic [CMD_BITS-1:0] cmd;
      logic [ID_BITS-1:0]  id;
      logic [KEY_BITS-1:0] value;
      bit                  pinned;
      answer_type          answer;
   } script_row_type;

   bit                     clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   logic [CMD_BITS-1:0]    req_cmd = CMD_QUERY;
   logic [ID_BITS-1:0]     req_entry_id = '0;
   logic [KEY_BITS-1:0]    req_value = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   logic [STATUS_BITS-1:0] rsp_status;
   logic [ID_BITS-1:0]     rsp_top_id;
   logic [KEY_BITS-1:0]    rsp_top_key;

   // answer typed into the script for the word on offer, if any
   bit         offer_pinned = 1'b0;
   answer_type offer_answer = '0;

   // shadow of the queue contents
   bit                    occupied [ENTRIES];
   logic [KEY_BITS-1:0]   key_of   [ENTRIES];
   logic [STAMP_BITS-1:0] stamp_of [ENTRIES];
   logic [6:0]            occupancy = '0;
   logic [STAMP_BITS-1:0] stamp_next = '0;

   answer_type     pending_answers[$];
   script_row_type script[$];

   bit hold_off_req = 1'b0;
   int faults = 0;
   int words_in = 0;
   int answers_seen = 0;
   int peak_occupancy = 0;
   int input_stall_cycles = 0;
   int status_seen [5];

   indexed_max_priority_queue dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_cmd      (req_cmd),
      .req_entry_id (req_entry_id),
      .req_value    (req_value),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_status   (rsp_status),
      .rsp_top_id   (rsp_top_id),
      .rsp_top_key  (rsp_top_key)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Apply one command to the shadow queue and return the answer it earns.
   function automatic answer_type run_command(input logic [CMD_BITS-1:0] cmd,
                                              input logic [ID_BITS-1:0]  id,
                                              input logic [KEY_BITS-1:0] value);
      answer_type        a;
      int                best;
      logic [KEY_BITS:0] sum;
      a = '0;
      a.status = ST_OK;
      if (cmd == CMD_QUERY) begin
         best = -1;
         for (int i = 0; i < ENTRIES; i++) begin
            if (occupied[i] && (best < 0 || key_of[i] > key_of[best] ||
                (key_of[i] == key_of[best] && stamp_of[i] < stamp_of[best])))
               best = i;
         end
         if (occupancy == 0 || best < 0) begin
            a.status = ST_EMPTY;
         end else begin
            a.top_id  = ID_BITS'(best);
            a.top_key = key_of[best];
         end
      end else if (int'(id) >= ENTRIES) begin
         a.status = ST_UNKNOWN;
      end else if (cmd == CMD_INSERT) begin
         if (occupied[id]) begin
            a.status = ST_PRESENT;
         end else if (stamp_next == '1) begin
            a.status = ST_EXHAUSTED;
         end else begin
            occupied[id] = 1'b1;
            key_of[id]   = value;
            stamp_of[id] = stamp_next;
            stamp_next   = stamp_next + 1'b1;
            occupancy    = occupancy + 1'b1;
         end
      end else if (!occupied[id]) begin
         a.status = ST_UNKNOWN;
      end else if (cmd == CMD_ADD) begin
         sum = {1'b0, key_of[id]} + {1'b0, value};
         // saturate on overflow
         key_of[id] = sum[KEY_BITS] ? '1 : sum[KEY_BITS-1:0];
      end else begin
         occupied[id] = 1'b0;
         occupancy    = occupancy - 1'b1;
      end
      if (int'(occupancy) > peak_occupancy)
         peak_occupancy = int'(occupancy);
      return a;
   endfunction

   // Pick an id that is held (or free) in the shadow queue, any id if none.
   function automatic logic [ID_BITS-1:0] pick_id(input bit want_held);
      int ids[$];
      for (int i = 0; i < ENTRIES; i++)
         if (occupied[i] == want_held)
            ids = {ids, i};
      if (ids.size() == 0)
         return ID_BITS'($urandom_range(0, ENTRIES - 1));
      return ID_BITS'(ids[$urandom_range(0, ids.size() - 1)]);
   endfunction

   // Keys mix random values, the two extremes, values near the top, small values and a few repeated values for ties.
   function automatic logic [KEY_BITS-1:0] pick_value();
      case ($urandom_range(0, 9))
         0, 1, 2: return KEY_BITS'($urandom);
         3:       return '0;
         4:       return '1;
         5:       return KEY_BITS'($urandom_range(65000, 65535));
         6, 7:    return KEY_BITS'($urandom_range(0, 3) * 1000);
         default: return KEY_BITS'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic void add_script_row(input logic [CMD_BITS-1:0]    cmd,
                                          input int                     id,
                                          input int                     value,
                                          input bit                     pinned,
                                          input logic [STATUS_BITS-1:0] status,
                                          input int                     top_id,
                                          input int                     top_key);
      script_row_type r;
      r.cmd    = cmd;
      r.id     = ID_BITS'(id);
      r.value  = KEY_BITS'(value);
      r.pinned = pinned;
      r.answer = '{status, ID_BITS'(top_id), KEY_BITS'(top_key)};
      script   = {script, r};
   endfunction

   // Offer one word and hold it until accepted.
   task automatic offer(input logic [CMD_BITS-1:0] cmd, input logic [ID_BITS-1:0] id,
                        input logic [KEY_BITS-1:0] value, input bit pinned,
                        input answer_type answer);
      @(negedge clock);
      req_valid    <= 1'b1;
      req_cmd      <= cmd;
      req_entry_id <= id;
      req_value    <= value;
      offer_pinned <= pinned;
      offer_answer <= answer;
      do
         @(posedge clock);
      while (!req_ready);
   endtask

   task automatic idle_for(input int cycles);
      @(negedge clock);
      req_valid <= 1'b0;
      repeat (cycles - 1) @(negedge clock);
   endtask

   task automatic drain_wait();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_answers.size() != 0) @(negedge clock);
   endtask

   // Predict on every accepted command word.
   always @(posedge clock) begin
      answer_type predicted;
      if (!reset && req_valid && req_ready) begin
         predicted = run_command(req_cmd, req_entry_id, req_value);
         pending_answers = {pending_answers, offer_pinned ? offer_answer : predicted};
         words_in++;
      end
      if (!reset && req_valid && !req_ready)
         input_stall_cycles++;
   end

   // Check every accepted answer against the oldest expectation.
   always @(posedge clock) begin
      answer_type got;
      answer_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         got = '{rsp_status, rsp_top_id, rsp_top_key};
         answers_seen++;
         if (pending_answers.size() == 0) begin
            faults++;
            if (faults <= 10)
               $display("%0t: unexpected answer status %0d id %0d key %0d",
                        $time, got.status, got.top_id, got.top_key);
         end else begin
            want = pending_answers.pop_front();
            if (want.status < 5)
               status_seen[want.status]++;
            if (got.status !== want.status || got.top_id !== want.top_id ||
                got.top_key !== want.top_key) begin
               faults++;
               if (faults <= 10)
                  $display({"%0t: mismatch, expected status %0d id %0d key %0d,",
                            " got status %0d id %0d key %0d"}, $time,
                           want.status, want.top_id, want.top_key,
                           got.status, got.top_id, got.top_key);
            end
         end
      end
   end

   // Receiver: stall on a changing pattern, and hold off for a long stretch on request.
   initial begin
      int mode;
      int left;
      int phase;
      mode  = 0;
      left  = 0;
      phase = 0;
      forever begin
         @(negedge clock);
         if (hold_off_req) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_off_req = 1'b0;
         end else begin
            if (left == 0) begin
               mode = $urandom_range(0, 3);
               left = $urandom_range(20, 200);
            end
            left--;
            phase++;
            case (mode)
               0:       rsp_ready <= 1'b1;
               1:       rsp_ready <= ($urandom_range(0, 3) != 0);
               2:       rsp_ready <= ($urandom_range(0, 3) == 0);
               default: rsp_ready <= (phase % 3 == 0);
            endcase
         end
      end
   end

   // Watchdog: end the run if no word moves on either channel for too long.
   initial begin
      int quiet;
      quiet = 0;
      wait (reset == 1'b0);
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("timeout: no handshake for %0d cycles, %0d answers outstanding",
               QUIET_LIMIT, pending_answers.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      int                  burst_left;
      int                  pick;
      bit                  grow;
      logic [CMD_BITS-1:0] cmd;
      logic [ID_BITS-1:0]  id;
      logic [KEY_BITS-1:0] value;

      add_script_row(CMD_QUERY,  63, 'hFFFF, 1'b1, ST_EMPTY,   0,  0);
      add_script_row(CMD_ADD,     7, 5,      1'b1, ST_UNKNOWN, 0,  0);
      add_script_row(CMD_REMOVE, 63, 0,      1'b1, ST_UNKNOWN, 0,  0);
      add_script_row(CMD_INSERT,  0, 0,      1'b1, ST_OK,      0,  0);
      add_script_row(CMD_QUERY,  21, 'hAAAA, 1'b1, ST_OK,      0,  0);
      add_script_row(CMD_INSERT, 63, 'hFFFF, 1'b1, ST_OK,      0,  0);
      add_script_row(CMD_INSERT, 63, 1,      1'b1, ST_PRESENT, 0,  0);
      add_script_row(CMD_QUERY,   0, 0,      1'b1, ST_OK,      63, 'hFFFF);
      // sum overflows and must stick at the top key
      add_script_row(CMD_ADD,    63, 'hFFFF, 1'b1, ST_OK,      0,  0);
      add_script_row(CMD_QUERY,   0, 0,      1'b1, ST_OK,      63, 'hFFFF);
      // equal key, later arrival: must not win
      add_script_row(CMD_INSERT, 42, 'hFFFF, 1'b1, ST_OK,      0,  0);
      add_script_row(CMD_QUERY,   0, 0,      1'b1, ST_OK,      63, 'hFFFF);
      add_script_row(CMD_REMOVE, 63, 0,      1'b1, ST_OK,      0,  0);
      add_script_row(CMD_QUERY,   0, 0,      1'b1, ST_OK,      42, 'hFFFF);
      add_script_row(CMD_ADD,     0, 'hFFFE, 1'b1, ST_OK,      0,  0);
      add_script_row(CMD_ADD,     0, 1,      1'b1, ST_OK,      0,  0);
      // now tied with 42 but older, so it wins
      add_script_row(CMD_QUERY,   0, 0,      1'b1, ST_OK,      0,  'hFFFF);
      add_script_row(CMD_REMOVE, 63, 0,      1'b1, ST_UNKNOWN, 0,  0);
      add_script_row(CMD_INSERT, 63, 1234,   1'b0, ST_OK,      0,  0);
      add_script_row(CMD_ADD,    63, 0,      1'b0, ST_OK,      0,  0);
      add_script_row(CMD_REMOVE,  0, 0,      1'b0, ST_OK,      0,  0);
      add_script_row(CMD_REMOVE, 42, 0,      1'b0, ST_OK,      0,  0);
      add_script_row(CMD_QUERY,   5, 7,      1'b0, ST_OK,      0,  0);
      add_script_row(CMD_REMOVE, 63, 0,      1'b0, ST_OK,      0,  0);
      add_script_row(CMD_QUERY,   0, 0,      1'b1, ST_EMPTY,   0,  0);

      repeat (8) @(negedge clock);
      reset <= 1'b0;

      foreach (script[i]) begin
         if ($urandom_range(0, 3) == 0)
            idle_for($urandom_range(1, 6));
         offer(script[i].cmd, script[i].id, script[i].value, script[i].pinned,
               script[i].answer);
      end
      drain_wait();

      burst_left = 0;
      for (int k = 0; k < RANDOM_WORDS; k++) begin
         if (k == RANDOM_WORDS / 2)
            drain_wait();
         // stall the receiver and keep offering so the input backs up
         if (k == 250) begin
            hold_off_req = 1'b1;
            burst_left   = 40;
         end
         if (burst_left == 0) begin
            idle_for(($urandom_range(0, 3) == 0) ? $urandom_range(10, 30)
                                                 : $urandom_range(1, 6));
            burst_left = $urandom_range(1, 40);
         end
         burst_left--;

         // alternate between filling and emptying the queue
         grow  = ((k / 120) % 2) == 0;
         pick  = $urandom_range(0, 99);
         value = pick_value();
         if (pick < (grow ? 45 : 15)) begin
            cmd = CMD_INSERT;
            id  = pick_id($urandom_range(0, 9) == 0);
         end else if (pick < (grow ? 65 : 35)) begin
            cmd = CMD_ADD;
            id  = pick_id($urandom_range(0, 9) != 0);
         end else if (pick < (grow ? 75 : 70)) begin
            cmd = CMD_REMOVE;
            id  = pick_id($urandom_range(0, 9) != 0);
         end else begin
            cmd = CMD_QUERY;
            id  = ID_BITS'($urandom);
         end
         if ($urandom_range(0, 9) == 0)
            id = ID_BITS'($urandom);
         offer(cmd, id, value, 1'b0, '0);
      end

      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_answers.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      $display({"covered %0d command words, %0d answers: %0d ok, %0d empty,",
                " %0d unknown id, %0d already present"},
               words_in, answers_seen, status_seen[0], status_seen[1], status_seen[2],
               status_seen[3]);
      $display("peak occupancy %0d of %0d, input held back for %0d cycles, %0d faults",
               peak_occupancy, ENTRIES, input_stall_cycles, faults);
      if (faults == 0 && pending_answers.size() == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
